>>> design/char_lcd_diff_refresh_macros.svh
// assertion macros shared by the character display front end
// no dependencies; included by char_lcd_diff_refresh
`ifndef CHAR_LCD_DIFF_REFRESH_MACROS_SVH
`define CHAR_LCD_DIFF_REFRESH_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CLDR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CLDR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/cldr_pkg.sv
// shared constants, control word type and microcode table of the display front end
// no dependencies; used by char_lcd_diff_refresh
package cldr_pkg;

	localparam int LINE_WIDTH = 20;
	localparam int LINE_COUNT = 4;
	localparam int DEPTH      = LINE_WIDTH * LINE_COUNT;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int COL_W      = $clog2(LINE_WIDTH);
	localparam int ZERO_ROWS_INIT = (LINE_COUNT < 2) ? LINE_COUNT : 2;

	// input operations
	localparam logic [1:0] OP_STORE   = 2'd0;
	localparam logic [1:0] OP_REFRESH = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;
	localparam logic [1:0] OP_INIT    = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_LINE0_BASE = 2'd0;
	localparam logic [1:0] REG_LINE1_BASE = 2'd1;
	localparam logic [1:0] REG_LINE2_BASE = 2'd2;
	localparam logic [1:0] REG_LINE3_BASE = 2'd3;

	// display commands
	localparam logic [7:0] CMD_SET_ADDR = 8'h80;
	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CMD_HOME     = 8'h02;
	localparam logic [7:0] CMD_FUNC_SET = 8'h28;
	localparam logic [7:0] CMD_DISP_ON  = 8'h0c;
	localparam logic [7:0] CMD_ENTRY    = 8'h06;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;

	// emit sources
	localparam logic [1:0] EM_NONE = 2'd0;
	localparam logic [1:0] EM_CMD  = 2'd1;
	localparam logic [1:0] EM_ADDR = 2'd2;
	localparam logic [1:0] EM_CHAR = 2'd3;

	// jump conditions
	localparam logic [2:0] C_NEXT     = 3'd0;
	localparam logic [2:0] C_ALWAYS   = 3'd1;
	localparam logic [2:0] C_SAME     = 3'd2;
	localparam logic [2:0] C_NOSKIP   = 3'd3;
	localparam logic [2:0] C_MORE     = 3'd4;
	localparam logic [2:0] C_ROW_MORE = 3'd5;

	// program steps
	localparam int PC_W = 5;
	localparam logic [PC_W-1:0] PC_IDLE        = 5'd0;
	localparam logic [PC_W-1:0] PC_REF_ADDR    = 5'd1;
	localparam logic [PC_W-1:0] PC_REF_RD      = 5'd2;
	localparam logic [PC_W-1:0] PC_REF_EVAL    = 5'd3;
	localparam logic [PC_W-1:0] PC_REF_SKIPCHK = 5'd4;
	localparam logic [PC_W-1:0] PC_REF_RADDR   = 5'd5;
	localparam logic [PC_W-1:0] PC_REF_CHAR    = 5'd6;
	localparam logic [PC_W-1:0] PC_REF_ADV     = 5'd7;
	localparam logic [PC_W-1:0] PC_END         = 5'd8;
	localparam logic [PC_W-1:0] PC_REF_SKIP    = 5'd9;
	localparam logic [PC_W-1:0] PC_CLR_ZERO    = 5'd10;
	localparam logic [PC_W-1:0] PC_CLR_CMD     = 5'd11;
	localparam logic [PC_W-1:0] PC_INI_ZERO    = 5'd12;
	localparam logic [PC_W-1:0] PC_INI_HOME    = 5'd13;
	localparam logic [PC_W-1:0] PC_INI_FUNC    = 5'd14;
	localparam logic [PC_W-1:0] PC_INI_CLEAR   = 5'd15;
	localparam logic [PC_W-1:0] PC_INI_DISP    = 5'd16;
	localparam logic [PC_W-1:0] PC_INI_ENTRY   = 5'd17;

	typedef struct packed {
		logic [1:0]      emit;     // result source of this step
		logic [7:0]      cmd;      // command byte for EM_CMD
		logic            rd;       // read both buffers at the current column
		logic            eval;     // copy pending byte to shown, close prefix unless both are nonzero
		logic            zero;     // zero first byte of the current row
		logic            adv;      // step to the next column
		logic            set_skip; // mark an unchanged run
		logic [2:0]      cond;     // jump condition
		logic [PC_W-1:0] target;   // jump target
		logic            fin;      // flush the staged result as last, go idle
	} ucode_t;

	function automatic ucode_t uc(input logic [1:0] emit, input logic [7:0] cmd,
			input logic [4:0] flags, input logic [2:0] cond,
			input logic [PC_W-1:0] target, input logic fin);
		ucode_t w;
		w.emit     = emit;
		w.cmd      = cmd;
		w.rd       = flags[4];
		w.eval     = flags[3];
		w.zero     = flags[2];
		w.adv      = flags[1];
		w.set_skip = flags[0];
		w.cond     = cond;
		w.target   = target;
		w.fin      = fin;
		return w;
	endfunction

	// flag order: rd, eval, zero, adv, set_skip
	function automatic ucode_t uc_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		unique case (pc)
			PC_REF_ADDR:    w = uc(EM_ADDR, 8'h00, 5'b00000, C_NEXT,     PC_IDLE,     1'b0);
			PC_REF_RD:      w = uc(EM_NONE, 8'h00, 5'b10000, C_NEXT,     PC_IDLE,     1'b0);
			PC_REF_EVAL:    w = uc(EM_NONE, 8'h00, 5'b01000, C_SAME,     PC_REF_SKIP, 1'b0);
			PC_REF_SKIPCHK: w = uc(EM_NONE, 8'h00, 5'b00000, C_NOSKIP,   PC_REF_CHAR, 1'b0);
			PC_REF_RADDR:   w = uc(EM_ADDR, 8'h00, 5'b00000, C_NEXT,     PC_IDLE,     1'b0);
			PC_REF_CHAR:    w = uc(EM_CHAR, 8'h00, 5'b00000, C_NEXT,     PC_IDLE,     1'b0);
			PC_REF_ADV:     w = uc(EM_NONE, 8'h00, 5'b00010, C_MORE,     PC_REF_RD,   1'b0);
			PC_END:         w = uc(EM_NONE, 8'h00, 5'b00000, C_NEXT,     PC_IDLE,     1'b1);
			PC_REF_SKIP:    w = uc(EM_NONE, 8'h00, 5'b00001, C_ALWAYS,   PC_REF_ADV,  1'b0);
			PC_CLR_ZERO:    w = uc(EM_NONE, 8'h00, 5'b00100, C_ROW_MORE, PC_CLR_ZERO, 1'b0);
			PC_CLR_CMD:     w = uc(EM_CMD, CMD_CLEAR, 5'b00000, C_ALWAYS, PC_END,     1'b0);
			PC_INI_ZERO:    w = uc(EM_NONE, 8'h00, 5'b00100, C_ROW_MORE, PC_INI_ZERO, 1'b0);
			PC_INI_HOME:    w = uc(EM_CMD, CMD_HOME,     5'b00000, C_NEXT, PC_IDLE,   1'b0);
			PC_INI_FUNC:    w = uc(EM_CMD, CMD_FUNC_SET, 5'b00000, C_NEXT, PC_IDLE,   1'b0);
			PC_INI_CLEAR:   w = uc(EM_CMD, CMD_CLEAR,    5'b00000, C_NEXT, PC_IDLE,   1'b0);
			PC_INI_DISP:    w = uc(EM_CMD, CMD_DISP_ON,  5'b00000, C_NEXT, PC_IDLE,   1'b0);
			PC_INI_ENTRY:   w = uc(EM_CMD, CMD_ENTRY,    5'b00000, C_ALWAYS, PC_END,  1'b0);
			default:        w = uc(EM_NONE, 8'h00, 5'b00000, C_NEXT,     PC_IDLE,     1'b1);
		endcase
		return w;
	endfunction

endpackage

>>> design/cldr_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies; used for both text buffers of char_lcd_diff_refresh
module cldr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 80
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> design/char_lcd_diff_refresh.sv
// top level of the character display front end with differential line refresh
// depends on cldr_pkg, cldr_ram and char_lcd_diff_refresh_macros.svh
//
// usage:
//   s_axis carries one request per transaction: tuser = op, tdata = line, column,
//   char_value. m_axis carries one display byte per transaction: tdata = byte,
//   tuser = is_data, long_wait; tlast marks the final byte of a request.
//   cfg writes the four line base addresses; writes are taken at any time but
//   are meant for idle periods.
// timing:
//   a store gives no output. clear and start-up zero rows, then send their commands.
//   a refresh sends the line address, then per column reads both buffers and
//   sends a character for each changed or tail column, after a new address
//   where one goes out, and skips each unchanged column. one control step
//   per cycle unless a stalled receiver holds the sequencer; one buffer read
//   per column. a request is accepted only while the sequencer is idle; the
//   final byte sits in the output register while the next request is taken.
// reset: both text buffers read as empty (per-entry valid bits), line bases
//   return to 0x00, 0x40, 0x14, 0x54, and the output is empty.
// stall: a stalled receiver holds the sequencer at its next emitting or
//   finishing step; nothing is dropped.
`include "char_lcd_diff_refresh_macros.svh"

module char_lcd_diff_refresh (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	// requests
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // line[1:0], column[6:2], char_value[14:7], zero
	input  logic [1:0]  s_axis_tuser,   // op[1:0]
	// display bytes
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // byte_value[7:0]
	output logic [1:0]  m_axis_tuser,   // is_data[0], long_wait[1]
	output logic        m_axis_tlast
);

	import cldr_pkg::*;

	typedef struct packed {
		logic       is_data;
		logic [7:0] value;
		logic       long_wait;
	} result_t;

	logic [1:0]        in_op;
	logic [1:0]        in_line;
	logic [4:0]        in_column;
	logic [7:0]        in_char;
	logic              in_acc;

	logic [6:0]        base_q [4];
	logic [PC_W-1:0]   pc_q;
	logic [1:0]        line_q;
	logic [COL_W-1:0]  col_q;
	logic [1:0]        row_q;
	logic [2:0]        zlim_q;
	logic              prefix_q;
	logic              tail_q;
	logic              skipped_q;

	logic              stage_v_q;
	result_t           stage_q;
	logic              out_v_q;
	result_t           out_q;
	logic              out_last_q;

	logic [DEPTH-1:0]  pv_q;
	logic [DEPTH-1:0]  sv_q;
	logic              pvr_q;
	logic              svr_q;

	ucode_t            uw;
	logic              active;
	logic              out_free;
	logic              go;
	logic              jump;
	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] row_addr;
	logic [ADDR_W-1:0] store_addr;
	logic [7:0]        p_rd;
	logic [7:0]        s_rd;
	logic [7:0]        nw;
	logic [7:0]        od;
	logic              both_nz;
	logic              same;
	logic              tail_has;
	logic [6:0]        addr_sum;
	result_t           new_res;

	logic              p_we;
	logic [ADDR_W-1:0] p_waddr;
	logic [7:0]        p_wdata;
	logic              s_we;
	logic [ADDR_W-1:0] s_waddr;
	logic [7:0]        s_wdata;

	assign in_op     = s_axis_tuser;
	assign in_line   = s_axis_tdata[1:0];
	assign in_column = s_axis_tdata[6:2];
	assign in_char   = s_axis_tdata[14:7];

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (pc_q == PC_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign active = (pc_q != PC_IDLE);
	assign uw     = uc_rom(pc_q);

	assign cur_addr   = ADDR_W'(32'(line_q) * LINE_WIDTH + 32'(col_q));
	assign row_addr   = ADDR_W'(32'(row_q) * LINE_WIDTH);
	assign store_addr = ADDR_W'(32'(in_line) * LINE_WIDTH + 32'(in_column));

	// entries never written read as zero
	assign nw = pvr_q ? p_rd : 8'h00;
	assign od = svr_q ? s_rd : 8'h00;

	assign both_nz  = (nw != 8'h00) && (od != 8'h00);
	assign same     = prefix_q && both_nz && (nw == od);
	assign tail_has = tail_q && (nw != 8'h00);
	assign addr_sum = base_q[line_q] + 7'(col_q);

	always_comb begin
		new_res = '0;
		unique case (uw.emit)
			EM_CMD: begin
				new_res.is_data = 1'b0;
				new_res.value   = uw.cmd;
			end
			EM_ADDR: begin
				new_res.is_data = 1'b0;
				new_res.value   = CMD_SET_ADDR | {1'b0, addr_sum};
			end
			EM_CHAR: begin
				new_res.is_data = 1'b1;
				new_res.value   = (prefix_q || tail_has) ? nw : CHAR_SPACE;
			end
			default: begin
				new_res = '0;
			end
		endcase
		new_res.long_wait = !new_res.is_data && (new_res.value == CMD_CLEAR);
	end

	always_comb begin
		unique case (uw.cond)
			C_ALWAYS:   jump = 1'b1;
			C_SAME:     jump = same;
			C_NOSKIP:   jump = !skipped_q;
			C_MORE:     jump = (32'(col_q) + 1) < LINE_WIDTH;
			C_ROW_MORE: jump = (3'(row_q) + 3'd1) < zlim_q;
			default:    jump = 1'b0;
		endcase
	end

	// the staged result moves out only once its successor or the end is known
	assign out_free = !out_v_q || m_axis_tready;
	assign go = !(active && stage_v_q && ((uw.emit != EM_NONE) || uw.fin) && !out_free);

	// buffer write ports
	always_comb begin
		p_we    = 1'b0;
		p_waddr = store_addr;
		p_wdata = in_char;
		s_we    = 1'b0;
		s_waddr = cur_addr;
		s_wdata = nw;
		if (in_acc && in_op == OP_STORE && 32'(in_line) < LINE_COUNT &&
				32'(in_column) < LINE_WIDTH) begin
			p_we = 1'b1;
		end
		if (active && uw.zero) begin
			p_we    = 1'b1;
			p_waddr = row_addr;
			p_wdata = 8'h00;
			s_we    = 1'b1;
			s_waddr = row_addr;
			s_wdata = 8'h00;
		end
		if (active && uw.eval) begin
			s_we = 1'b1;
		end
	end

	cldr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_pending (
		.clk     (clk),
		.wr_en   (p_we),
		.wr_addr (p_waddr),
		.wr_data (p_wdata),
		.rd_en   (active && uw.rd),
		.rd_addr (cur_addr),
		.rd_data (p_rd)
	);

	cldr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_shown (
		.clk     (clk),
		.wr_en   (s_we),
		.wr_addr (s_waddr),
		.wr_data (s_wdata),
		.rd_en   (active && uw.rd),
		.rd_addr (cur_addr),
		.rd_data (s_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q  <= '0;
			sv_q  <= '0;
			pvr_q <= 1'b0;
			svr_q <= 1'b0;
		end else begin
			if (p_we) begin
				pv_q[p_waddr] <= 1'b1;
			end
			if (s_we) begin
				sv_q[s_waddr] <= 1'b1;
			end
			if (active && uw.rd) begin
				pvr_q <= pv_q[cur_addr];
				svr_q <= sv_q[cur_addr];
			end
		end
	end

	// line base registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q[0] <= 7'h00;
			base_q[1] <= 7'h40;
			base_q[2] <= 7'h14;
			base_q[3] <= 7'h54;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LINE0_BASE: base_q[0] <= cfg_data;
				REG_LINE1_BASE: base_q[1] <= cfg_data;
				REG_LINE2_BASE: base_q[2] <= cfg_data;
				REG_LINE3_BASE: base_q[3] <= cfg_data;
				default:        base_q[0] <= base_q[0];
			endcase
		end
	end

	// sequencer and walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= PC_IDLE;
			line_q    <= '0;
			col_q     <= '0;
			row_q     <= '0;
			zlim_q    <= '0;
			prefix_q  <= 1'b0;
			tail_q    <= 1'b0;
			skipped_q <= 1'b0;
		end else if (!active) begin
			if (in_acc) begin
				line_q    <= in_line;
				col_q     <= '0;
				row_q     <= '0;
				prefix_q  <= 1'b1;
				tail_q    <= 1'b1;
				skipped_q <= 1'b0;
				unique case (in_op)
					OP_REFRESH: begin
						if (32'(in_line) < LINE_COUNT) begin
							pc_q <= PC_REF_ADDR;
						end
					end
					OP_CLEAR: begin
						zlim_q <= 3'(LINE_COUNT);
						pc_q   <= PC_CLR_ZERO;
					end
					OP_INIT: begin
						zlim_q <= 3'(ZERO_ROWS_INIT);
						pc_q   <= PC_INI_ZERO;
					end
					default: begin
						pc_q <= PC_IDLE;
					end
				endcase
			end
		end else if (go) begin
			if (uw.eval && prefix_q && !both_nz) begin
				prefix_q <= 1'b0;
			end
			if (uw.emit == EM_ADDR) begin
				skipped_q <= 1'b0;
			end
			if (uw.set_skip) begin
				skipped_q <= 1'b1;
			end
			if (uw.emit == EM_CHAR && !prefix_q && !tail_has) begin
				tail_q <= 1'b0;
			end
			if (uw.adv) begin
				col_q <= col_q + COL_W'(1);
			end
			if (uw.zero) begin
				row_q <= row_q + 2'd1;
			end
			priority if (uw.fin) begin
				pc_q <= PC_IDLE;
			end else if (jump) begin
				pc_q <= uw.target;
			end else begin
				pc_q <= pc_q + PC_W'(1);
			end
		end
	end

	// staging register and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_v_q  <= 1'b0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (active && go && stage_v_q && ((uw.emit != EM_NONE) || uw.fin)) begin
				out_v_q    <= 1'b1;
				out_q      <= stage_q;
				out_last_q <= uw.fin;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			if (active && go && uw.emit != EM_NONE) begin
				stage_v_q <= 1'b1;
				stage_q   <= new_res;
			end else if (active && go && uw.fin) begin
				stage_v_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q.value;
	assign m_axis_tuser  = {out_q.long_wait, out_q.is_data};
	assign m_axis_tlast  = out_last_q;

	`CLDR_ASSERT_IMP(a_idle_stage_empty, clk, arst_n, s_axis_tready, !stage_v_q,
		"request taken while a result is still staged")
	`CLDR_ASSERT_IMP(a_long_wait_clear, clk, arst_n, m_axis_tvalid && m_axis_tuser[1],
		m_axis_tdata == CMD_CLEAR && !m_axis_tuser[0],
		"long wait flag on a byte other than the clear command")
	// the column counter sits one past the line during the finishing step
	`CLDR_ASSERT_IMP(a_col_range, clk, arst_n, active, 32'(col_q) <= LINE_WIDTH,
		"column counter left the line")
	`CLDR_ASSERT_NXT(a_refresh_start, clk, arst_n,
		in_acc && in_op == OP_REFRESH && 32'(in_line) < LINE_COUNT,
		pc_q == PC_REF_ADDR, "refresh did not start at the line address step")

endmodule
